// ----- design/vsp_pkg.sv -----
`timescale 1ns / 1ps

package vsp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CfgAddrBits = 3;

  typedef struct packed {
    logic              mode;
    logic [1:0]        matrix_select;
    logic [3:0]        element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               w_zero;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_WCHK,
    ST_DINIT,
    ST_DSTEP,
    ST_DEND,
    ST_VMUL,
    ST_VEND,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_LOAD_PT,
    OP_MUL,
    OP_ACC,
    OP_COPY,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_VP_MUL,
    OP_VP_END,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] stage;
    logic [1:0] row;
    logic [1:0] col;
    logic       sel;
  } cmd_t;

  typedef struct packed {
    logic w_is_zero;
    logic out_busy;
  } status_t;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_XFORM = 1'b1;

  localparam logic [1:0] SEL_MODEL  = 2'd0;
  localparam logic [1:0] SEL_VIEW   = 2'd1;
  localparam logic [1:0] SEL_PROJ   = 2'd2;
  localparam logic [1:0] SEL_UNUSED = 2'd3;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/vsp_ctrl.sv -----
`timescale 1ns / 1ps

module vsp_ctrl #(
  parameter int FRAC_BITS = vsp_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_mode,
  output logic            in_stall,
  output vsp_pkg::cmd_t   cmd,
  input  vsp_pkg::status_t status
);
  import vsp_pkg::*;

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW);
  localparam logic [5:0] LastTerm = 6'b10_11_11;

  state_t        state, state_next;
  logic [5:0]    term;
  logic [CW-1:0] dcnt;
  logic          sel;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid && in_mode == MODE_XFORM) state_next = ST_MUL;
      ST_MUL:   state_next = ST_ACC;
      ST_ACC:   state_next = (term == LastTerm) ? ST_WCHK : ST_MUL;
      ST_WCHK:  state_next = status.w_is_zero ? ST_VMUL : ST_DINIT;
      ST_DINIT: state_next = ST_DSTEP;
      ST_DSTEP: if (dcnt == CW'(DW - 1)) state_next = ST_DEND;
      ST_DEND:  state_next = sel ? ST_VMUL : ST_DINIT;
      ST_VMUL:  state_next = ST_VEND;
      ST_VEND:  state_next = sel ? ST_OUT : ST_VMUL;
      ST_OUT:   if (!status.out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.stage = term[5:4];
    cmd.row   = term[3:2];
    cmd.col   = term[1:0];
    cmd.sel   = sel;
    in_stall  = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:  if (in_valid) cmd.op = (in_mode == MODE_XFORM) ? OP_LOAD_PT : OP_WRITE;
      ST_MUL:   cmd.op = OP_MUL;
      ST_ACC:   cmd.op = OP_ACC;
      ST_WCHK:  if (status.w_is_zero) cmd.op = OP_COPY;
      ST_DINIT: cmd.op = OP_DIV_INIT;
      ST_DSTEP: cmd.op = OP_DIV_STEP;
      ST_DEND:  cmd.op = OP_DIV_END;
      ST_VMUL:  cmd.op = OP_VP_MUL;
      ST_VEND:  cmd.op = OP_VP_END;
      ST_OUT:   if (!status.out_busy) cmd.op = OP_OUT;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      term  <= '0;
      dcnt  <= '0;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          term <= '0;
          sel  <= 1'b0;
        end
        ST_ACC:   term <= term + 6'd1;
        ST_WCHK:  sel <= 1'b0;
        ST_DINIT: dcnt <= '0;
        ST_DSTEP: dcnt <= dcnt + CW'(1);
        ST_DEND:  sel <= ~sel;
        ST_VEND:  sel <= 1'b1;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- design/vsp_dp.sv -----
`timescale 1ns / 1ps

module vsp_dp #(
  parameter int FRAC_BITS = vsp_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  vsp_pkg::cmd_t     cmd,
  output vsp_pkg::status_t  status,
  input  vsp_pkg::in_item_t in_item,
  input  logic [13:0]       width,
  input  logic [13:0]       height,
  output logic              out_valid,
  input  logic              out_stall,
  output vsp_pkg::out_item_t out_item
);
  import vsp_pkg::*;

  localparam int DW = 32 + FRAC_BITS;
  localparam int TW = 64 - FRAC_BITS;
  localparam int AW = TW + 2;
  localparam logic signed [32:0] One = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] Half = 64'sd1 <<< (FRAC_BITS - 1);

  logic [31:0]        mat_m [16];
  logic [31:0]        mat_v [16];
  logic [31:0]        mat_p [16];
  logic [31:0]        coef;
  logic signed [31:0] vin [4];
  logic signed [31:0] vout [3];
  logic signed [63:0] prod;
  logic signed [AW-1:0] acc;
  logic signed [31:0] ndc_x, ndc_y, scr_x, scr_y;
  logic               wz;
  logic [DW-1:0]      dq;
  logic [31:0]        drem, ddiv;
  logic               qneg;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] rnd;
  logic signed [TW-1:0] term;
  logic signed [AW-1:0] acc_next;
  logic signed [31:0] acc_sat;
  logic signed [31:0] num;
  logic [32:0]        rem2;
  logic               ge;
  logic signed [DW:0] qs, qres;
  logic signed [63:0] vp_half;

  assign status.w_is_zero = (vin[3] == 32'sd0);
  assign status.out_busy  = out_valid && out_stall;

  always_comb begin
    unique case (cmd.stage)
      SEL_MODEL: coef = mat_m[{cmd.col, cmd.row}];
      SEL_VIEW:  coef = mat_v[{cmd.col, cmd.row}];
      default:   coef = mat_p[{cmd.col, cmd.row}];
    endcase
    if (cmd.op == OP_VP_MUL) begin
      mul_a = cmd.sel ? (One - 33'(ndc_y)) : (33'(ndc_x) + One);
      mul_b = cmd.sel ? {19'd0, height} : {19'd0, width};
    end else begin
      mul_a = 33'(signed'(coef));
      mul_b = 33'(vin[cmd.col]);
    end
    mul_p = mul_a * mul_b;

    // Round to nearest with ties upward, then drop the fraction bits.
    rnd      = (prod + Half) >>> FRAC_BITS;
    term     = rnd[TW-1:0];
    acc_next = acc + AW'(term);
    acc_sat  = sat32(66'(acc_next));

    num  = cmd.sel ? vin[1] : vin[0];
    rem2 = {drem, dq[DW-1]};
    ge   = (rem2 >= {1'b0, ddiv});
    qs   = {1'b0, dq};
    qres = qneg ? -qs : qs;

    vp_half = (prod + 64'sd1) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat_m[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? One[31:0] : 32'd0;
        mat_v[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? One[31:0] : 32'd0;
        mat_p[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? One[31:0] : 32'd0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_WRITE) begin
        unique case (in_item.matrix_select)
          SEL_MODEL: mat_m[in_item.element_index] <= in_item.element_value;
          SEL_VIEW:  mat_v[in_item.element_index] <= in_item.element_value;
          SEL_PROJ:  mat_p[in_item.element_index] <= in_item.element_value;
          default: begin
          end
        endcase
      end
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD_PT: begin
        vin[0] <= in_item.point_x;
        vin[1] <= in_item.point_y;
        vin[2] <= in_item.point_z;
        vin[3] <= One[31:0];
        acc    <= '0;
        wz     <= 1'b0;
      end
      OP_MUL: prod <= mul_p[63:0];
      OP_ACC: begin
        if (cmd.col == 2'd3) begin
          acc <= '0;
          // The last row of a stage closes it: its results feed the next one.
          if (cmd.row == 2'd3) begin
            vin[0] <= vout[0];
            vin[1] <= vout[1];
            vin[2] <= vout[2];
            vin[3] <= acc_sat;
          end else begin
            vout[cmd.row] <= acc_sat;
          end
        end else begin
          acc <= acc_next;
        end
      end
      OP_COPY: begin
        ndc_x <= vin[0];
        ndc_y <= vin[1];
        wz    <= 1'b1;
      end
      OP_DIV_INIT: begin
        dq   <= {32'(num[31] ? -num : num), FRAC_BITS'(0)};
        ddiv <= 32'(vin[3][31] ? -vin[3] : vin[3]);
        drem <= '0;
        qneg <= num[31] ^ vin[3][31];
      end
      OP_DIV_STEP: begin
        drem <= ge ? 32'(rem2 - {1'b0, ddiv}) : rem2[31:0];
        dq   <= {dq[DW-2:0], ge};
      end
      OP_DIV_END: begin
        if (cmd.sel) ndc_y <= sat32(66'(qres));
        else         ndc_x <= sat32(66'(qres));
      end
      OP_VP_MUL: prod <= mul_p[63:0];
      OP_VP_END: begin
        if (cmd.sel) scr_y <= sat32(66'(vp_half));
        else         scr_x <= sat32(66'(vp_half));
      end
      OP_OUT: begin
        out_item.screen_x <= scr_x;
        out_item.screen_y <= scr_y;
        out_item.w_zero   <= wz;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/vertex_screen_projection_top.sv -----
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// in       | in_valid / in_stall  | in_item  (vsp_pkg::in_item_t)
// out      | out_valid / out_stall| out_item (vsp_pkg::out_item_t)
// config   | APB psel / penable   | paddr, pwdata, prdata
//
// A load item is accepted without holding the input stalled. A transform item
// holds the input stalled for the three matrix stages on the one shared
// multiplier (multiply, then accumulate), the w check, the bit-serial divider
// for x and y (skipped when clip w is zero), the viewport for x and y and the
// output hand-off. Reset loads identity matrices and zero screen size.
// A stalled result waits in the output register while the next item is
// accepted; only the final hand-off of a transform waits on it.

module vertex_screen_projection_top #(
  parameter int FRAC_BITS = vsp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  vsp_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output vsp_pkg::out_item_t            out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vsp_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import vsp_pkg::*;

  cmd_t        cmd;
  status_t     status;
  logic [13:0] width, height;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {18'd0, height} : {18'd0, width};

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= '0;
      height <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) height <= pwdata[13:0];
      else          width  <= pwdata[13:0];
    end
  end

  vsp_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (in_item.mode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  vsp_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .width     (width),
    .height    (height),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_busy_after_transform: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_item.mode == MODE_XFORM) |=> in_stall)
    else $error("transform item did not hold the input stalled");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_item.mode == MODE_LOAD && !out_valid) |=> !out_valid)
    else $error("load item produced a result");

  a_load_single_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_item.mode == MODE_LOAD) |=> !in_stall)
    else $error("load item held the input stalled");

  a_width_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && !paddr[2]) |=> (width == $past(pwdata[13:0])))
    else $error("screen width not written");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import vsp_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) <<< FRAC;
  localparam logic [CfgAddrBits-1:0] ADDR_WIDTH = 3'd0;
  localparam logic [CfgAddrBits-1:0] ADDR_HEIGHT = 3'd4;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 630;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_item;
  out_item_t out_item;
  logic psel, penable, pwrite, pready;
  logic [CfgAddrBits-1:0] paddr;
  logic [31:0] pwdata, prdata;

  vertex_screen_projection_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct {
    in_item_t item;
    bit       typed;
    out_item_t screen;
  } dir_row_t;

  logic signed [31:0] mats [3][16];
  logic [13:0] vp_width, vp_height;
  out_item_t pending_screens[$];
  int mismatches = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit quiet = 0;
  int stall_left = 0;
  dir_row_t dir_rows[$];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void stage_mul(logic [1:0] m, longint v[4], output longint o[4]);
    longint acc, p;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) begin
        p = longint'(mats[m][c*4+r]) * v[c];
        acc += (p + (ONE >>> 1)) >>> FRAC;
      end
      o[r] = sat32(acc);
    end
  endfunction

  function automatic longint persp_div(longint n, longint d);
    longint a, b, q;
    a = (n < 0) ? -n : n;
    b = (d < 0) ? -d : d;
    q = (a <<< FRAC) / b;
    return sat32(((n < 0) != (d < 0)) ? -q : q);
  endfunction

  function automatic void identity_all();
    for (int m = 0; m < 3; m++)
      for (int i = 0; i < 16; i++)
        mats[m][i] = (i % 5 == 0) ? 32'sh00010000 : 32'sh0;
  endfunction

  // Updates the matrix copy for a load and queues the screen point for a transform.
  function automatic void project_item(in_item_t it);
    longint p[4], a[4], b[4], c[4];
    longint nx, ny;
    out_item_t s;
    if (it.mode == MODE_LOAD) begin
      if (it.matrix_select != SEL_UNUSED)
        mats[it.matrix_select][it.element_index] = it.element_value;
      return;
    end
    p[0] = longint'(it.point_x);
    p[1] = longint'(it.point_y);
    p[2] = longint'(it.point_z);
    p[3] = ONE;
    stage_mul(SEL_MODEL, p, a);
    stage_mul(SEL_VIEW, a, b);
    stage_mul(SEL_PROJ, b, c);
    s.w_zero = (c[3] == 0);
    if (c[3] != 0) begin
      nx = persp_div(c[0], c[3]);
      ny = persp_div(c[1], c[3]);
    end else begin
      nx = c[0];
      ny = c[1];
    end
    s.screen_x = 32'(sat32(((nx + ONE) * longint'(vp_width) + 1) >>> 1));
    s.screen_y = 32'(sat32(((ONE - ny) * longint'(vp_height) + 1) >>> 1));
    pending_screens.insert(pending_screens.size(), s);
  endfunction

  function automatic in_item_t load_item(logic [1:0] sel, logic [3:0] idx,
                                         logic [31:0] val);
    in_item_t it;
    it = '{default: '0};
    it.mode = MODE_LOAD;
    it.matrix_select = sel;
    it.element_index = idx;
    it.element_value = val;
    return it;
  endfunction

  function automatic in_item_t xform_item(logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z);
    in_item_t it;
    it = '{default: '0};
    it.mode = MODE_XFORM;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
    endcase
  endfunction

  task automatic push_row(in_item_t it, bit typed = 0, out_item_t s = '0);
    dir_row_t r;
    r.item = it;
    r.typed = typed;
    r.screen = s;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic send(in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    project_item(it);
    items_sent++;
    if (items_sent >= 560) quiet = 1;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Walks the directed table. A typed result is first held against the
  // predictor; that prediction is taken back so that send queues it once.
  task automatic run_rows();
    out_item_t s;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        project_item(dir_rows[i].item);
        s = pending_screens[pending_screens.size() - 1];
        pending_screens.delete(pending_screens.size() - 1);
        if (s !== dir_rows[i].screen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row %0d: expected x=%h y=%h wz=%b, predictor x=%h y=%h wz=%b",
                     i, dir_rows[i].screen.screen_x, dir_rows[i].screen.screen_y,
                     dir_rows[i].screen.w_zero, s.screen_x, s.screen_y, s.w_zero);
        end
      end
      send(dir_rows[i].item);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_screens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic [CfgAddrBits-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_WIDTH) vp_width = data[13:0];
    else if (addr == ADDR_HEIGHT) vp_height = data[13:0];
  endtask

  task automatic set_viewport(logic [13:0] w, logic [13:0] h);
    reg_write(ADDR_WIDTH, {18'h3FFFF, w});
    reg_write(ADDR_HEIGHT, {18'h2AAAA, h});
  endtask

  // Random traffic: transforms, single matrix loads and raw random items, with runs that zero
  // the projection w row to reach the no-divide path and runs that reset one matrix to identity.
  task automatic random_phase(int count);
    int n;
    int r;
    logic [1:0] sel;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 19);
      if (r < 9) begin
        send(xform_item(rand_value(), rand_value(), rand_value()));
        n++;
      end else if (r < 14) begin
        sel = 2'($urandom_range(0, 2));
        send(load_item(sel, 4'($urandom_range(0, 15)), rand_value()));
        n++;
      end else if (r < 16) begin
        for (int i = 3; i < 16; i += 4) send(load_item(SEL_PROJ, 4'(i), 32'h0));
        send(xform_item(rand_value(), rand_value(), rand_value()));
        n += 5;
      end else if (r < 18) begin
        sel = 2'($urandom_range(0, 2));
        for (int i = 0; i < 16; i++)
          send(load_item(sel, 4'(i), (i % 5 == 0) ? 32'h00010000 : 32'h0));
        n += 16;
      end else begin
        in_item_t it;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        send(it);
        n++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_screens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", out_item);
      end else begin
        want = pending_screens.pop_front();
        if (out_item.screen_x !== want.screen_x || out_item.screen_y !== want.screen_y
            || out_item.w_zero !== want.w_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h wz=%b, got x=%h y=%h wz=%b",
                     want.screen_x, want.screen_y, want.w_zero,
                     out_item.screen_x, out_item.screen_y, out_item.w_zero);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    identity_all();
    vp_width = 0;
    vp_height = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero viewport after reset maps every point to the origin.
    push_row(xform_item(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F), 1, '0);
    run_rows();
    drain();
    set_viewport(14'd640, 14'd480);

    dir_rows.delete();
    push_row(xform_item(32'h0, 32'h0, 32'h0), 1, {32'h01400000, 32'h00F00000, 1'b0});
    push_row(xform_item(32'h7FFFFFFF, 32'h80000000, 32'h0), 1,
             {32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0});
    push_row(load_item(SEL_PROJ, 4'd15, 32'h0));
    push_row(xform_item(32'h00010000, 32'h00020000, 32'h0), 1,
             {32'h02800000, 32'hFF100000, 1'b1});
    push_row(xform_item(32'h80000000, 32'h7FFFFFFF, 32'h80000000));
    push_row(load_item(SEL_PROJ, 4'd15, 32'h00010000));
    push_row(load_item(SEL_MODEL, 4'd0, 32'h80000000));
    push_row(load_item(SEL_MODEL, 4'd15, 32'h7FFFFFFF));
    push_row(xform_item(32'hFFFFFFFF, 32'h00000001, 32'h7FFFFFFF));
    push_row(load_item(SEL_VIEW, 4'd14, 32'hFFFF8000));
    push_row(load_item(SEL_PROJ, 4'd11, 32'hFFFF0000));
    push_row(xform_item(32'h00030000, 32'hFFFD0000, 32'h00050000));
    // An unused select leaves every matrix alone.
    push_row(load_item(SEL_UNUSED, 4'd0, 32'hDEADBEEF));
    begin
      in_item_t it;
      it = load_item(SEL_MODEL, 4'd0, 32'h00010000);
      it.point_x = 32'hFFFFFFFF;
      it.point_z = 32'h80000000;
      push_row(it);
      push_row(load_item(SEL_MODEL, 4'd15, 32'h00010000));
      it = xform_item(32'h00008000, 32'hFFFF8000, 32'h0);
      it.matrix_select = SEL_MODEL;
      it.element_index = 4'hF;
      it.element_value = 32'hFFFFFFFF;
      push_row(it);
    end
    push_row(load_item(SEL_VIEW, 4'd14, 32'h0));
    push_row(load_item(SEL_PROJ, 4'd11, 32'h0));
    push_row(xform_item(32'h00008000, 32'h00008000, 32'h0));
    run_rows();
    drain();

    set_viewport(14'd8192, 14'd8192);
    random_phase(RANDOM_ITEMS / 4);
    drain();
    set_viewport(14'd0, 14'd8192);
    random_phase(RANDOM_ITEMS / 4);
    drain();
    set_viewport(14'd16383, 14'd1);
    random_phase(RANDOM_ITEMS / 4);
    drain();
    set_viewport(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
    random_phase(RANDOM_ITEMS / 4);
    drain();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
